// ===== src/move_to_front_list_assert.svh =====
// Assertion macros for the move-to-front list RTL
`ifndef MOVE_TO_FRONT_LIST_ASSERT_SVH
`define MOVE_TO_FRONT_LIST_ASSERT_SVH

// Condition holds on every clock outside reset
`define MTFL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define MTFL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define MTFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mtfl_pkg.sv =====
// Types and codes for the move-to-front list
`default_nettype none

package mtfl_pkg;

  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REWIND = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_END  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/move_to_front_list.sv =====
// Move-to-front list top level: request intake, sequencer and response register
//
// Requests arrive on the s_ channel: s_tuser carries the action (add, get with
// move to front, rewind, next), s_tdata the value. One response per request
// leaves on the m_ channel: m_tuser is the status, m_tdata holds the returned
// value, the entry count after the request and the cursor-still-valid flag.
// Requests are handled one at a time; s_tready is high only while the
// sequencer is idle. Add and get scan the entry RAM one entry at a time
// through a single comparator (RAM read, then compare), and a get hit at
// position p shifts p entries, each by a RAM read then a write, before the
// value is written at the head. A response waiting in the register does not
// block the next request; the sequencer only holds its result while the
// register is full and m_tready is low. m_tvalid stays high with stable data
// while m_tready is low. Synchronous reset empties the list, ends the cursor
// and drops m_tvalid; the entry RAM itself is not cleared.
`default_nettype none

module move_to_front_list import mtfl_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OW = ((DATA_W + CW + 1 + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // value
  input  wire logic [ACT_W-1:0]  s_tuser,   // action
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OW-1:0]     m_tdata,   // data_out, count, more, zero pad
  output logic      [ST_W-1:0]   m_tuser    // status
);

  req_t          req;
  rsp_t          rsp;
  logic          rsp_valid;
  logic          rsp_ready;
  logic [CW-1:0] rsp_count;
  logic          rsp_more;
  logic [OW-1:0] pack;

  assign req.action = s_tuser;
  assign req.value  = s_tdata;
  assign rsp_ready  = !m_tvalid || m_tready;

  mtfl_core #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .rsp_count(rsp_count),
    .rsp_more (rsp_more)
  );

  always_comb begin
    pack               = '0;
    pack[DATA_W-1:0]   = rsp.data;
    pack[DATA_W +: CW] = rsp_count;
    pack[DATA_W + CW]  = rsp_more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_tvalid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      m_tdata <= pack;
      m_tuser <= rsp.status;
    end
  end

endmodule

`default_nettype wire

// ===== src/mtfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module mtfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/mtfl_core.sv =====
// Sequencer for the list: scan, shift and cursor logic around one entry RAM
`default_nettype none
`include "move_to_front_list_assert.svh"

module mtfl_core import mtfl_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire req_t          req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rsp_t               rsp,
  output logic [CW-1:0]      rsp_count,
  output logic               rsp_more
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_SHRD = 4'd3;
  localparam logic [3:0] S_SHWR = 4'd4;
  localparam logic [3:0] S_HEAD = 4'd5;
  localparam logic [3:0] S_ADDW = 4'd6;
  localparam logic [3:0] S_NRD  = 4'd7;
  localparam logic [3:0] S_NOUT = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  localparam logic [CW-1:0] ENDED = CW'(DEPTH);

  logic [3:0]        state;
  logic [ACT_W-1:0]  action;
  logic [WIDTH-1:0]  val;
  logic [AW-1:0]     scan;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cursor;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] data;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WIDTH-1:0]  wdata;
  logic [AW-1:0]     raddr;
  logic [WIDTH-1:0]  rdata;

  logic [WIDTH+DATA_W-1:0] val_ext;
  logic [WIDTH+DATA_W-1:0] rd_ext;
  logic [DATA_W-1:0]       rd32;
  logic                    hit;
  logic                    last;
  logic [CW-1:0]           cursor_inc;

  assign val_ext    = {{WIDTH{1'b0}}, req.value};
  assign rd_ext     = {{DATA_W{1'b0}}, rdata};
  assign rd32       = rd_ext[DATA_W-1:0];
  assign hit        = (rdata == val);
  assign last       = (CW'(scan) + CW'(1)) == count;
  assign cursor_inc = cursor + CW'(1);

  assign req_ready  = (state == S_IDLE);
  assign rsp_valid  = (state == S_RESP);
  assign rsp.status = status;
  assign rsp.data   = data;
  assign rsp_count  = count;
  assign rsp_more   = (cursor < count);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = val;
    raddr = scan;
    case (state)
      S_SHRD: raddr = idx - AW'(1);
      S_NRD:  raddr = cursor[AW-1:0];
      S_SHWR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_HEAD: begin
        we    = 1'b1;
        waddr = '0;
      end
      S_ADDW: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
      end
      default: ;
    endcase
  end

  mtfl_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= ENDED;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            action <= req.action;
            val    <= val_ext[WIDTH-1:0];
            scan   <= '0;
            data   <= '0;
            case (req.action)
              ACT_ADD: begin
                state <= (count == '0) ? S_ADDW : S_SRD;
              end
              ACT_GET: begin
                if (count == '0) begin
                  status <= ST_MISS;
                  state  <= S_RESP;
                end else begin
                  state <= S_SRD;
                end
              end
              ACT_REWIND: begin
                cursor <= (count != '0) ? '0 : ENDED;
                status <= ST_OK;
                state  <= S_RESP;
              end
              default: begin
                if (cursor < count) begin
                  state <= S_NRD;
                end else begin
                  cursor <= ENDED;
                  status <= ST_END;
                  state  <= S_RESP;
                end
              end
            endcase
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (hit) begin
            if (action == ACT_ADD) begin
              status <= ST_MISS;
              state  <= S_RESP;
            end else begin
              status <= ST_OK;
              data   <= rd32;
              if (cursor < count) begin
                if (cursor == CW'(scan)) begin
                  cursor <= '0;
                end else if (CW'(scan) > cursor) begin
                  cursor <= cursor_inc;
                end
              end
              idx   <= scan;
              state <= (scan == '0) ? S_RESP : S_SHRD;
            end
          end else if (last) begin
            if (action == ACT_ADD) begin
              if (count == ENDED) begin
                status <= ST_FULL;
                state  <= S_RESP;
              end else begin
                state <= S_ADDW;
              end
            end else begin
              status <= ST_MISS;
              state  <= S_RESP;
            end
          end else begin
            scan  <= scan + AW'(1);
            state <= S_SRD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          idx   <= idx - AW'(1);
          state <= (idx == AW'(1)) ? S_HEAD : S_SHRD;
        end
        S_HEAD: state <= S_RESP;
        S_ADDW: begin
          count  <= count + CW'(1);
          status <= ST_OK;
          state  <= S_RESP;
        end
        S_NRD: state <= S_NOUT;
        S_NOUT: begin
          data   <= rd32;
          status <= ST_OK;
          cursor <= (cursor_inc >= count) ? ENDED : cursor_inc;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MTFL_ASSERT_ALWAYS(a_count_bound, count <= ENDED, "entry count beyond depth")
  `MTFL_ASSERT_ALWAYS(a_cursor_legal, (cursor == ENDED) || (cursor < count),
                      "cursor neither ended nor on an entry")
  `MTFL_ASSERT_NEXT(a_count_hold, state != S_ADDW, count == $past(count),
                    "entry count changed outside an append")
  `MTFL_ASSERT_NEXT(a_resp_release, rsp_valid && rsp_ready, req_ready,
                    "sequencer not idle after response taken")

endmodule

`default_nettype wire
